[rtl/core/hss_pkg.sv]
`timescale 1ns / 1ps

package hss_pkg;

    localparam int MAX_GRID = 256;
    localparam int POS_W = $clog2(MAX_GRID);
    localparam int VAL_W = 16;
    localparam int HOT_W = 16;
    localparam int SIZE_W = 9;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_POS_W = 8;
    localparam int RAM_W = 2 * VAL_W;

    localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(64);
    localparam logic [VAL_W-1:0] THRESH_RESET = VAL_W'(410);
    localparam logic [HOT_W-1:0] HOT_MAX = {HOT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOT_THRESHOLD = CFG_IDX_W'(1);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic emit;
        logic done;
        logic first;
    } item_t;

endpackage

[rtl/core/hss_ram.sv]
`timescale 1ns / 1ps

module hss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/hss_scan.sv]
`timescale 1ns / 1ps

module hss_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hss_pkg::VAL_W-1:0]      cell_value,
    input  logic                           advance,
    output hss_pkg::item_t                 item,
    output logic                           item_valid,
    output logic                           rd_en,
    output logic [hss_pkg::POS_W-1:0]      rd_addr,
    output logic [hss_pkg::VAL_W-1:0]      hot_threshold
);

    logic [hss_pkg::SIZE_W-1:0] grid_size_reg;
    logic [hss_pkg::VAL_W-1:0]  thresh_reg;
    logic [hss_pkg::POS_W-1:0]  row_reg;
    logic [hss_pkg::POS_W-1:0]  row_next;
    logic [hss_pkg::POS_W-1:0]  col_reg;
    logic [hss_pkg::POS_W-1:0]  col_next;
    logic                       item_valid_reg;
    logic                       item_valid_next;
    hss_pkg::item_t             item_reg;
    logic [31:0]                n_full;
    logic [hss_pkg::POS_W-1:0]  n_last;
    logic                       accept;
    logic                       cfg_write;
    logic                       row_end;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign in_ready = !item_valid_reg || advance;
    assign accept = in_valid & in_ready;

    always_comb
    begin
        n_full = 32'(grid_size_reg);
        if (n_full < 32'd3)
        begin
            n_full = 32'd3;
        end
        if (n_full > 32'(hss_pkg::MAX_GRID))
        begin
            n_full = 32'(hss_pkg::MAX_GRID);
        end
        n_last = hss_pkg::POS_W'(n_full - 32'd1);
    end

    assign row_end = (col_reg == n_last);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_write && cfg_index == hss_pkg::REG_GRID_SIZE)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = (row_reg == n_last) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= hss_pkg::GRID_RESET;
            thresh_reg     <= hss_pkg::THRESH_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == hss_pkg::REG_GRID_SIZE)
            begin
                grid_size_reg <= cfg_data[hss_pkg::SIZE_W-1:0];
            end
            if (cfg_write && cfg_index == hss_pkg::REG_HOT_THRESHOLD)
            begin
                thresh_reg <= cfg_data[hss_pkg::VAL_W-1:0];
            end
            row_reg        <= row_next;
            col_reg        <= col_next;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.value <= cell_value;
            item_reg.row   <= row_reg;
            item_reg.col   <= col_reg;
            item_reg.emit  <= (row_reg >= hss_pkg::POS_W'(2)) && (col_reg >= hss_pkg::POS_W'(2));
            item_reg.done  <= (row_reg == n_last) && row_end;
            item_reg.first <= (row_reg == '0) && (col_reg == '0);
        end
    end

    assign item = item_reg;
    assign item_valid = item_valid_reg;
    assign rd_en = accept;
    assign rd_addr = col_reg;
    assign hot_threshold = thresh_reg;

endmodule

[rtl/core/hss_stencil.sv]
`timescale 1ns / 1ps

module hss_stencil (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hss_pkg::item_t                item,
    input  logic                          item_valid,
    input  logic [hss_pkg::RAM_W-1:0]     rd_data,
    input  logic [hss_pkg::VAL_W-1:0]     hot_threshold,
    output logic                          advance,
    output logic                          wr_en,
    output logic [hss_pkg::POS_W-1:0]     wr_addr,
    output logic [hss_pkg::RAM_W-1:0]     wr_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hss_pkg::VAL_W-1:0]     new_value,
    output logic [hss_pkg::OUT_POS_W-1:0] cell_row,
    output logic [hss_pkg::OUT_POS_W-1:0] cell_col,
    output logic [hss_pkg::HOT_W-1:0]     hot_count,
    output logic                          sweep_done
);

    logic [hss_pkg::VAL_W-1:0]     mid_c;
    logic [hss_pkg::VAL_W-1:0]     above_c;
    logic [hss_pkg::VAL_W-1:0]     mid1_reg;
    logic [hss_pkg::VAL_W-1:0]     mid2_reg;
    logic [hss_pkg::VAL_W-1:0]     above1_reg;
    logic [hss_pkg::VAL_W-1:0]     last1_reg;
    logic [hss_pkg::HOT_W-1:0]     hot_reg;
    logic [hss_pkg::HOT_W-1:0]     hot_next;
    logic [hss_pkg::HOT_W-1:0]     hot_base;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [hss_pkg::VAL_W-1:0]     new_value_reg;
    logic [hss_pkg::OUT_POS_W-1:0] cell_row_reg;
    logic [hss_pkg::OUT_POS_W-1:0] cell_col_reg;
    logic [hss_pkg::HOT_W-1:0]     hot_count_reg;
    logic                          sweep_done_reg;
    logic [hss_pkg::VAL_W+1:0]     nb_sum;
    logic [hss_pkg::VAL_W+1:0]     centre4;
    logic [hss_pkg::VAL_W+2:0]     total;
    logic [hss_pkg::VAL_W+1:0]     dev;
    logic [hss_pkg::VAL_W+1:0]     thresh4;
    logic                          hot_hit;
    logic                          out_free;
    logic                          load_out;

    assign above_c = rd_data[hss_pkg::RAM_W-1:hss_pkg::VAL_W];
    assign mid_c = rd_data[hss_pkg::VAL_W-1:0];

    assign out_free = !out_valid_reg || out_ready;
    assign advance = item_valid && (!item.emit || out_free);
    assign load_out = advance && item.emit;

    assign wr_en = advance;
    assign wr_addr = item.col;
    assign wr_data = {mid_c, item.value};

    always_comb
    begin
        nb_sum = (hss_pkg::VAL_W+2)'(above1_reg) + (hss_pkg::VAL_W+2)'(last1_reg)
               + (hss_pkg::VAL_W+2)'(mid2_reg) + (hss_pkg::VAL_W+2)'(mid_c);
        centre4 = {mid1_reg, 2'b00};
        total = (hss_pkg::VAL_W+3)'(nb_sum) + (hss_pkg::VAL_W+3)'(centre4);
        dev = (centre4 >= nb_sum) ? centre4 - nb_sum : nb_sum - centre4;
        thresh4 = {hot_threshold, 2'b00};
        hot_hit = dev > thresh4;
        hot_base = item.first ? '0 : hot_reg;
        hot_next = (hot_hit && hot_base != hss_pkg::HOT_MAX) ? hot_base + 1'b1 : hot_base;
    end

    always_comb
    begin
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hot_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                hot_reg <= item.emit ? hot_next : hot_base;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mid2_reg   <= mid1_reg;
            mid1_reg   <= mid_c;
            above1_reg <= above_c;
            last1_reg  <= item.value;
        end
        if (load_out)
        begin
            new_value_reg  <= total[hss_pkg::VAL_W+2:3];
            cell_row_reg   <= hss_pkg::OUT_POS_W'(item.row - 1'b1);
            cell_col_reg   <= hss_pkg::OUT_POS_W'(item.col - 1'b1);
            hot_count_reg  <= hot_next;
            sweep_done_reg <= item.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_value = new_value_reg;
    assign cell_row = cell_row_reg;
    assign cell_col = cell_col_reg;
    assign hot_count = hot_count_reg;
    assign sweep_done = sweep_done_reg;

endmodule

[rtl/core/heat_stencil_sweep_core.sv]
`timescale 1ns / 1ps
// channel   signals                               moves
// in        in_valid in_ready cell_value          one grid cell, row-major
// out       out_valid out_ready new_value         one interior cell update
//           cell_row cell_col hot_count sweep_done
// cfg       cfg_valid cfg_ready cfg_index         one register write
//           cfg_data
// one item per cycle unless out_ready stalls; a result passes the item and output registers
// the column memory is read on accept and written back as the item advances, one port each
// reset clears position, hot count and handshakes; no memory clearing pass is needed
// a stalled result holds the stencil stage; input stalls only when both are full

module heat_stencil_sweep_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hss_pkg::VAL_W-1:0]      cell_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [hss_pkg::VAL_W-1:0]      new_value,
    output logic [hss_pkg::OUT_POS_W-1:0]  cell_row,
    output logic [hss_pkg::OUT_POS_W-1:0]  cell_col,
    output logic [hss_pkg::HOT_W-1:0]      hot_count,
    output logic                           sweep_done
);

    hss_pkg::item_t                item;
    logic                          item_valid;
    logic                          advance;
    logic                          rd_en;
    logic [hss_pkg::POS_W-1:0]     rd_addr;
    logic [hss_pkg::RAM_W-1:0]     rd_data;
    logic                          wr_en;
    logic [hss_pkg::POS_W-1:0]     wr_addr;
    logic [hss_pkg::RAM_W-1:0]     wr_data;
    logic [hss_pkg::VAL_W-1:0]     hot_threshold;

    hss_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cell_value    (cell_value),
        .advance       (advance),
        .item          (item),
        .item_valid    (item_valid),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .hot_threshold (hot_threshold)
    );

    hss_ram #(
        .WIDTH (hss_pkg::RAM_W),
        .DEPTH (hss_pkg::MAX_GRID)
    ) u_rows (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    hss_stencil u_stencil (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .rd_data       (rd_data),
        .hot_threshold (hot_threshold),
        .advance       (advance),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .new_value     (new_value),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .hot_count     (hot_count),
        .sweep_done    (sweep_done)
    );

endmodule
